// File: rtl/scwm_pkg.sv
// ----------------------------------------------------------------------------
// scwm_pkg
// shared types and constants of the stereo correlation and width meter
// ----------------------------------------------------------------------------
package scwm_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int CORR_W     = 16;
   localparam int WIDTH_W    = 16;
   localparam int CROSS_W    = 60;
   localparam int SQ_W       = 59;
   localparam int DIFF_W     = 61;
   localparam int MAG_W      = 60;
   localparam int PROD_W     = 120;
   localparam int CNT_W      = 6;
   localparam int MUL_STEPS  = 60;
   localparam int DIV_STEPS  = 30;
   localparam int SQRT_STEPS = 15;
   localparam int WDIV_STEPS = 15;

   localparam logic [CORR_W-1:0]  CORR_ONE  = 16'h7FFF;
   localparam logic [WIDTH_W-1:0] WIDTH_ONE = 16'h8000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_MONO,
      ST_SETUP,
      ST_MUL,
      ST_DIVI,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_prod;
      logic accum;
      logic setup;
      logic mul_step;
      logic wdiv_step;
      logic div_init;
      logic div_step;
      logic sqrt_step;
      logic out_stereo;
      logic out_mono;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic mono;
      logic out_busy;
   } status_type;

endpackage

// File: rtl/scwm_req_if.sv
// ----------------------------------------------------------------------------
// scwm_req_if
// sample channel: one stereo sample pair with block flags
// ----------------------------------------------------------------------------
interface scwm_req_if;
   import scwm_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] left_sample;
   logic [SAMPLE_W-1:0] right_sample;
   logic                mono_block;
   logic                block_end;

   modport source (output valid, output left_sample, output right_sample,
                   output mono_block, output block_end, input ready);
   modport sink (input valid, input left_sample, input right_sample,
                 input mono_block, input block_end, output ready);
endinterface

// File: rtl/scwm_rsp_if.sv
// ----------------------------------------------------------------------------
// scwm_rsp_if
// result channel: correlation and stereo width of one block
// ----------------------------------------------------------------------------
interface scwm_rsp_if;
   import scwm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CORR_W-1:0]  correlation;
   logic [WIDTH_W-1:0] stereo_width;

   modport source (output valid, output correlation, output stereo_width, input ready);
   modport sink (input valid, input correlation, input stereo_width, output ready);
endinterface

// File: rtl/stereo_correlation_width_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_correlation_width_meter_core
// phase correlation and stereo width meter over blocks of stereo samples
// ----------------------------------------------------------------------------
// For each sample pair ST_IDLE forms the four products and ST_ACCUM adds
// them into saturating sums. The transaction that ends a stereo block then
// runs a shift-add multiplier (width division overlapped), a restoring
// divider and a square root before the result is loaded; a mono block end
// loads its result without this computation.
// The result waits in an output register; a new block can start while it is
// pending, and a block end stalls only if the previous result is still unread.
module stereo_correlation_width_meter_core #(
   parameter int SAMPLE_BITS = 24
) (
   input logic  clock,
   input logic  reset,
   scwm_req_if.sink   req,
   scwm_rsp_if.source rsp
);
   import scwm_pkg::*;

   cmd_type    cmd;
   status_type status;

   scwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scwm_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .left_sample  (req.left_sample),
      .right_sample (req.right_sample),
      .mono_block   (req.mono_block),
      .block_end    (req.block_end),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .correlation  (rsp.correlation),
      .stereo_width (rsp.stereo_width)
   );

endmodule

// File: rtl/scwm_dp.sv
// ----------------------------------------------------------------------------
// scwm_dp
// datapath: sample products, saturating sums, shift-add multiplier,
// restoring dividers, bitwise square root and result register
// ----------------------------------------------------------------------------
module scwm_dp #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [scwm_pkg::SAMPLE_W-1:0] left_sample,
   input  logic [scwm_pkg::SAMPLE_W-1:0] right_sample,
   input  logic                          mono_block,
   input  logic                          block_end,
   input  scwm_pkg::cmd_type             cmd,
   output scwm_pkg::status_type          status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scwm_pkg::CORR_W-1:0]   correlation,
   output logic [scwm_pkg::WIDTH_W-1:0]  stereo_width
);
   import scwm_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int DW = 2 * SAMPLE_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] l_s, r_s;
   logic signed [SAMPLE_BITS:0]   d_s;

   logic signed [PW-1:0] prod_lr_ff;
   logic signed [PW-1:0] prod_ll_ff, prod_rr_ff;
   logic signed [DW-1:0] prod_dd_ff;
   logic                 last_ff, mono_ff;

   logic signed [CROSS_W-1:0] sum_cross_ff;
   logic [SQ_W-1:0]           sum_left_sq_ff, sum_right_sq_ff;
   logic [DIFF_W-1:0]         sum_diff_sq_ff;
   logic [WIDTH_W-1:0]        held_width_ff;

   logic signed [CROSS_W:0] cross_add;
   logic [SQ_W:0]           left_add, right_add;
   logic [DIFF_W:0]         diff_add;

   logic                 neg_ff, lr_zero_ff;
   logic [MAG_W-1:0]     mag;
   logic [PROD_W-1:0]    ma_l_ff, ma_m_ff, acc_l_ff, acc_m_ff;
   logic [MAG_W-1:0]     mb_l_ff, mb_m_ff;

   logic [DIFF_W:0]      wden_ff, wrem_ff, wr2;
   logic                 wzero_ff, wfull_ff;
   logic [WIDTH_W-2:0]   wq_ff;

   logic [PROD_W:0]      rem_ff, r2;
   logic                 big_ff;
   logic [DIV_STEPS-1:0] dq_ff;
   logic [SQRT_STEPS-1:0] sq_bit_ff, sq_q_ff, trial;
   logic [2*SQRT_STEPS-1:0] trial_sq;

   logic [CORR_W-1:0]    q16, corr_val;
   logic [WIDTH_W-1:0]   width_val;
   logic                 rsp_valid_ff;
   logic [CORR_W-1:0]    corr_ff;
   logic [WIDTH_W-1:0]   width_ff;

   assign l_s = left_sample[SAMPLE_BITS-1:0];
   assign r_s = right_sample[SAMPLE_BITS-1:0];
   assign d_s = (SAMPLE_BITS+1)'(l_s) - (SAMPLE_BITS+1)'(r_s);

   assign cross_add = (CROSS_W+1)'(sum_cross_ff) + (CROSS_W+1)'(prod_lr_ff);
   assign left_add  = (SQ_W+1)'(sum_left_sq_ff) + (SQ_W+1)'(unsigned'(prod_ll_ff));
   assign right_add = (SQ_W+1)'(sum_right_sq_ff) + (SQ_W+1)'(unsigned'(prod_rr_ff));
   assign diff_add  = (DIFF_W+1)'(sum_diff_sq_ff) + (DIFF_W+1)'(unsigned'(prod_dd_ff));

   assign mag = sum_cross_ff[CROSS_W-1] ? MAG_W'(-sum_cross_ff) : MAG_W'(sum_cross_ff);

   assign wr2      = {wrem_ff[DIFF_W-1:0], 1'b0};
   assign r2       = {rem_ff[PROD_W-1:0], 1'b0};
   assign trial    = sq_q_ff | sq_bit_ff;
   assign trial_sq = trial * trial;

   always_comb begin
      q16 = big_ff ? CORR_W'(32768) : CORR_W'(sq_q_ff);
      if (lr_zero_ff) begin
         corr_val = CORR_ONE;
      end else if (neg_ff) begin
         corr_val = CORR_W'(-q16);
      end else if (big_ff) begin
         corr_val = CORR_ONE;
      end else begin
         corr_val = q16;
      end
      if (wzero_ff) begin
         width_val = '0;
      end else if (wfull_ff) begin
         width_val = WIDTH_ONE;
      end else begin
         width_val = WIDTH_W'(wq_ff);
      end
   end

   // sample products
   always_ff @(posedge clock) begin
      if (cmd.load_prod) begin
         prod_lr_ff <= PW'(l_s * r_s);
         prod_ll_ff <= PW'(l_s * l_s);
         prod_rr_ff <= PW'(r_s * r_s);
         prod_dd_ff <= DW'(d_s * d_s);
      end
   end

   // block flags
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
         mono_ff <= 1'b0;
      end else if (cmd.load_prod) begin
         last_ff <= block_end;
         mono_ff <= mono_block;
      end
   end

   // saturating sums and held width
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_cross_ff    <= '0;
         sum_left_sq_ff  <= '0;
         sum_right_sq_ff <= '0;
         sum_diff_sq_ff  <= '0;
         held_width_ff   <= '0;
      end else if (cmd.out_stereo || cmd.out_mono) begin
         sum_cross_ff    <= '0;
         sum_left_sq_ff  <= '0;
         sum_right_sq_ff <= '0;
         sum_diff_sq_ff  <= '0;
         if (cmd.out_stereo) begin
            held_width_ff <= width_val;
         end
      end else if (cmd.accum) begin
         if (cross_add[CROSS_W] != cross_add[CROSS_W-1]) begin
            sum_cross_ff <= cross_add[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                                : {1'b0, {(CROSS_W-1){1'b1}}};
         end else begin
            sum_cross_ff <= cross_add[CROSS_W-1:0];
         end
         sum_left_sq_ff  <= left_add[SQ_W] ? '1 : left_add[SQ_W-1:0];
         sum_right_sq_ff <= right_add[SQ_W] ? '1 : right_add[SQ_W-1:0];
         sum_diff_sq_ff  <= diff_add[DIFF_W] ? '1 : diff_add[DIFF_W-1:0];
      end
   end

   // multiplier, dividers and square root
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         neg_ff     <= sum_cross_ff[CROSS_W-1];
         lr_zero_ff <= (sum_left_sq_ff == '0) || (sum_right_sq_ff == '0);
         ma_l_ff    <= PROD_W'(sum_left_sq_ff);
         mb_l_ff    <= MAG_W'(sum_right_sq_ff);
         ma_m_ff    <= PROD_W'(mag);
         mb_m_ff    <= mag;
         acc_l_ff   <= '0;
         acc_m_ff   <= '0;
         wden_ff    <= {(DIFF_W)'(sum_left_sq_ff) + (DIFF_W)'(sum_right_sq_ff), 1'b0};
         wrem_ff    <= (DIFF_W+1)'(sum_diff_sq_ff);
         wzero_ff   <= (sum_left_sq_ff == '0) && (sum_right_sq_ff == '0);
         wfull_ff   <= (DIFF_W+1)'(sum_diff_sq_ff) >=
                       {(DIFF_W)'(sum_left_sq_ff) + (DIFF_W)'(sum_right_sq_ff), 1'b0};
         wq_ff      <= '0;
      end else begin
         if (cmd.mul_step) begin
            acc_l_ff <= mb_l_ff[0] ? acc_l_ff + ma_l_ff : acc_l_ff;
            acc_m_ff <= mb_m_ff[0] ? acc_m_ff + ma_m_ff : acc_m_ff;
            ma_l_ff  <= {ma_l_ff[PROD_W-2:0], 1'b0};
            ma_m_ff  <= {ma_m_ff[PROD_W-2:0], 1'b0};
            mb_l_ff  <= {1'b0, mb_l_ff[MAG_W-1:1]};
            mb_m_ff  <= {1'b0, mb_m_ff[MAG_W-1:1]};
         end
         if (cmd.wdiv_step) begin
            if (wr2 >= wden_ff) begin
               wrem_ff <= wr2 - wden_ff;
               wq_ff   <= {wq_ff[WIDTH_W-3:0], 1'b1};
            end else begin
               wrem_ff <= wr2;
               wq_ff   <= {wq_ff[WIDTH_W-3:0], 1'b0};
            end
         end
      end
      if (cmd.div_init) begin
         rem_ff    <= (PROD_W+1)'(acc_m_ff);
         big_ff    <= acc_l_ff <= acc_m_ff;
         dq_ff     <= '0;
         sq_bit_ff <= {1'b1, {(SQRT_STEPS-1){1'b0}}};
         sq_q_ff   <= '0;
      end else begin
         if (cmd.div_step) begin
            if (r2 >= (PROD_W+1)'(acc_l_ff)) begin
               rem_ff <= r2 - (PROD_W+1)'(acc_l_ff);
               dq_ff  <= {dq_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_ff <= r2;
               dq_ff  <= {dq_ff[DIV_STEPS-2:0], 1'b0};
            end
         end
         if (cmd.sqrt_step) begin
            if (trial_sq <= dq_ff) begin
               sq_q_ff <= trial;
            end
            sq_bit_ff <= {1'b0, sq_bit_ff[SQRT_STEPS-1:1]};
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_stereo || cmd.out_mono) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_stereo) begin
         corr_ff  <= corr_val;
         width_ff <= width_val;
      end else if (cmd.out_mono) begin
         corr_ff  <= CORR_ONE;
         width_ff <= held_width_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign correlation     = corr_ff;
   assign stereo_width    = width_ff;
   assign status.last     = last_ff;
   assign status.mono     = mono_ff;
   assign status.out_busy = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_stereo || cmd.out_mono) |-> !rsp_valid_ff)
      else $error("result loaded over a pending result");
   a_clear_sums: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_stereo || cmd.out_mono) |=> (sum_left_sq_ff == '0 && sum_right_sq_ff == '0))
      else $error("sums not cleared after block");
   a_mono_corr: assert property (@(posedge clock) disable iff (reset)
      cmd.out_mono |=> (corr_ff == CORR_ONE && rsp_valid_ff))
      else $error("mono block result wrong");

endmodule

// File: rtl/scwm_ctrl.sv
// ----------------------------------------------------------------------------
// scwm_ctrl
// controller: sequences accumulation and the end-of-block computation
// ----------------------------------------------------------------------------
module scwm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scwm_pkg::status_type status,
   output scwm_pkg::cmd_type    cmd
);
   import scwm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.mono) begin
               state_in = ST_MONO;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_MONO: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            state_in = ST_MUL;
            cnt_in   = CNT_W'(MUL_STEPS - 1);
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_DIVI;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIVI: begin
            state_in = ST_DIV;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_SQRT;
               cnt_in   = CNT_W'(SQRT_STEPS - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_prod = req_valid;
         end
         ST_ACCUM: cmd.accum    = 1'b1;
         ST_MONO:  cmd.out_mono = !status.out_busy;
         ST_SETUP: cmd.setup    = 1'b1;
         ST_MUL: begin
            cmd.mul_step  = 1'b1;
            cmd.wdiv_step = cnt_ff >= CNT_W'(MUL_STEPS - WDIV_STEPS);
         end
         ST_DIVI:  cmd.div_init   = 1'b1;
         ST_DIV:   cmd.div_step   = 1'b1;
         ST_SQRT:  cmd.sqrt_step  = 1'b1;
         ST_DONE:  cmd.out_stereo = !status.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < CNT_W'(MUL_STEPS)))
      else $error("multiplier step count out of range");
   a_last_computes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && status.last) |=> (state_ff != ST_IDLE))
      else $error("block end skipped result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.load_prod)
      else $error("sample taken during computation");

endmodule

// File: sim/tb_stereo_correlation_width_meter_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_correlation_width_meter_core
// Drives stereo sample blocks into the meter and compares every block
// result with a local bit-exact model of the saturating sums, the
// correlation square-root search and the width division. Covers full-scale
// and silent blocks, mono blocks, random blocks under sender idling and
// receiver stalls, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stereo_correlation_width_meter_core;
   import scwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CROSS_HI = (64'sd1 <<< 59) - 1;
   localparam longint CROSS_LO = -CROSS_HI - 1;
   localparam longint SQ_HI    = (64'sd1 <<< 59) - 1;
   localparam longint DIFF_HI  = (64'sd1 <<< 61) - 1;
   localparam int     QUIET_LIMIT = 20000;

   typedef struct packed {
      logic [CORR_W-1:0]  correlation;
      logic [WIDTH_W-1:0] stereo_width;
   } meter_result_type;

   logic clock;
   logic reset;

   scwm_req_if req ();
   scwm_rsp_if rsp ();

   stereo_correlation_width_meter_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // model state
   longint             acc_cross, acc_lsq, acc_rsq, acc_dsq;
   logic [WIDTH_W-1:0] last_width;
   meter_result_type   pending_results[$];

   int send_gap_pct, stall_pct, hold_cycles;
   int mismatches, results_seen, items_sent, mono_blocks, quiet_cycles;

   function automatic logic fits_below(longint unsigned q, logic [191:0] lr,
                                       logic [191:0] rhs);
      logic [191:0] t;
      t = 192'(q * q) * lr;
      return t <= rhs;
   endfunction

   function automatic logic [CORR_W-1:0] correlation_of_sums();
      logic [191:0]    lr, rhs;
      longint unsigned mag, q, trial;
      logic            neg;
      if (acc_lsq == 0 || acc_rsq == 0) return CORR_ONE;
      neg = acc_cross < 0;
      mag = neg ? -acc_cross : acc_cross;
      lr  = 192'(acc_lsq) * 192'(acc_rsq);
      rhs = (192'(mag) * 192'(mag)) << 30;
      q = 0;
      if (fits_below(32768, lr, rhs)) begin
         q = 32768;
      end else begin
         for (int b = 14; b >= 0; b--) begin
            trial = q | (64'd1 << b);
            if (fits_below(trial, lr, rhs)) q = trial;
         end
      end
      if (!neg) return (q > 32767) ? CORR_ONE : q[15:0];
      return 16'((65536 - q) & 16'hFFFF);
   endfunction

   function automatic logic [WIDTH_W-1:0] width_of_sums();
      longint unsigned den, r, q;
      den = 2 * (acc_lsq + acc_rsq);
      r = acc_dsq;
      q = 0;
      if (den == 0) return '0;
      if (r >= den) return WIDTH_ONE;
      for (int i = 0; i < 15; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q[15:0];
   endfunction

   function automatic longint sat_add(longint a, longint b, longint hi);
      return (b > hi - a) ? hi : a + b;
   endfunction

   task automatic predict_meter(logic [SAMPLE_W-1:0] l_raw, logic [SAMPLE_W-1:0] r_raw,
                                logic mono, logic last);
      longint           l, r, p, d;
      meter_result_type res;
      l = longint'($signed(l_raw));
      r = longint'($signed(r_raw));
      p = l * r;
      d = l - r;
      if (p > 0 && acc_cross > CROSS_HI - p) acc_cross = CROSS_HI;
      else if (p < 0 && acc_cross < CROSS_LO - p) acc_cross = CROSS_LO;
      else acc_cross = acc_cross + p;
      acc_lsq = sat_add(acc_lsq, l * l, SQ_HI);
      acc_rsq = sat_add(acc_rsq, r * r, SQ_HI);
      acc_dsq = sat_add(acc_dsq, d * d, DIFF_HI);
      if (!last) return;
      if (mono) begin
         res.correlation = CORR_ONE;
         mono_blocks++;
      end else begin
         last_width = width_of_sums();
         res.correlation = correlation_of_sums();
      end
      res.stereo_width = last_width;
      pending_results.push_back(res);
      acc_cross = 0;
      acc_lsq = 0;
      acc_rsq = 0;
      acc_dsq = 0;
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                              logic mono, logic last);
      if ($urandom_range(99) < send_gap_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req.valid        <= 1'b1;
      req.left_sample  <= l;
      req.right_sample <= r;
      req.mono_block   <= mono;
      req.block_end    <= last;
      do @(posedge clock); while (!req.ready);
      predict_meter(l, r, mono, last);
      items_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic send_random_block(int max_len);
      int                  len, shape;
      logic [SAMPLE_W-1:0] l, r;
      len = $urandom_range(max_len, 1);
      shape = $urandom_range(4);
      for (int i = 0; i < len; i++) begin
         l = SAMPLE_W'($urandom);
         case (shape)
            0: r = l;
            1: r = -l;
            2: r = l >>> $urandom_range(3);
            3: r = (i % 2) ? l : '0;
            default: r = SAMPLE_W'($urandom);
         endcase
         if ($urandom_range(9) == 0) l = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         send_sample(l, r,
                     (i == len - 1) ? ($urandom_range(4) == 0) : 1'($urandom_range(1)),
                     i == len - 1);
      end
   endtask

   task automatic test_directed();
      send_sample(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1);
      send_sample(24'h800000, 24'h800000, 1'b0, 1'b1);
      send_sample(24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
      send_sample(24'h800000, 24'h7FFFFF, 1'b0, 1'b1);
      send_sample(24'h000000, 24'h000000, 1'b0, 1'b1);
      send_sample(24'h123456, 24'h000000, 1'b0, 1'b1);
      send_sample(24'h000000, 24'hFEDCBA, 1'b0, 1'b1);
      send_sample(24'h400000, 24'hC00000, 1'b1, 1'b0);
      send_sample(24'h400000, 24'h200000, 1'b1, 1'b1);
      send_sample(24'h000001, 24'hFFFFFF, 1'b0, 1'b0);
      send_sample(24'h555555, 24'hAAAAAA, 1'b0, 1'b0);
      send_sample(24'hAAAAAA, 24'h555555, 1'b0, 1'b1);
      send_sample(24'h000000, 24'h000000, 1'b1, 1'b1);
      send_sample(24'h000001, 24'h000001, 1'b0, 1'b0);
      send_sample(24'h7FFFFF, 24'h000001, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_random_phase(int gap_pct, int stall, int blocks);
      send_gap_pct = gap_pct;
      stall_pct = stall;
      repeat (blocks) send_random_block(10);
      drain_results();
   endtask

   task automatic test_backpressure();
      send_gap_pct = 0;
      stall_pct = 0;
      hold_cycles = 600;
      repeat (12) send_random_block(4);
      drain_results();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      meter_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result corr=%h width=%h", rsp.correlation,
                        rsp.stereo_width);
         end else begin
            want = pending_results.pop_front();
            if (rsp.correlation !== want.correlation ||
                rsp.stereo_width !== want.stereo_width) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected corr=%h width=%h, got corr=%h width=%h",
                           results_seen, want.correlation, want.stereo_width,
                           rsp.correlation, rsp.stereo_width);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.left_sample = '0;
      req.right_sample = '0;
      req.mono_block = 1'b0;
      req.block_end = 1'b0;
      rsp.ready = 1'b0;
      send_gap_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      mono_blocks = 0;
      quiet_cycles = 0;
      acc_cross = 0;
      acc_lsq = 0;
      acc_rsq = 0;
      acc_dsq = 0;
      last_width = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(0, 0, 25);
      test_random_phase(83, 0, 20);
      test_random_phase(0, 83, 20);
      test_random_phase(36, 36, 25);
      test_backpressure();
      test_random_phase(10, 10, 15);

      $display("covered %0d samples, %0d block results (%0d mono), full-scale and silent",
               items_sent, results_seen, mono_blocks);
      $display("idling, stalls and a long result hold-off were exercised");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  pending_results.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/scwm_pkg.sv
rtl/scwm_req_if.sv
rtl/scwm_rsp_if.sv
rtl/scwm_dp.sv
rtl/scwm_ctrl.sv
rtl/stereo_correlation_width_meter_core.sv
sim/tb_stereo_correlation_width_meter_core.sv
